### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

### rtl/b64_pkg.sv
package b64_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] UPPER_BASE = 8'h41;
   localparam logic [7:0] UPPER_LAST = 8'h5A;
   localparam logic [7:0] LOWER_BASE = 8'h61;
   localparam logic [7:0] LOWER_LAST = 8'h7A;
   localparam logic [7:0] DIGIT_BASE = 8'h30;
   localparam logic [7:0] DIGIT_LAST = 8'h39;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;

   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;
   localparam logic [1:0] LAST_SLOT = 2'd3;

   // one complete or final partial group of up to three bytes
   typedef struct packed {
      logic [23:0] bits;      // first byte in 23:16, missing bytes zero
      logic [1:0]  pad_count; // number of trailing '=' characters
      logic        eom;       // group closes the message
   } group_type;

   function automatic logic [7:0] encode_char(input logic [5:0] idx);
      logic [7:0] wide;
      wide = {2'b00, idx};
      if (idx < 6'd26) begin
         encode_char = UPPER_BASE + wide;
      end else if (idx < 6'd52) begin
         encode_char = LOWER_BASE + wide - 8'd26;
      end else if (idx < 6'd62) begin
         encode_char = DIGIT_BASE + wide - 8'd52;
      end else if (idx == 6'd62) begin
         encode_char = PLUS_CHAR;
      end else begin
         encode_char = SLASH_CHAR;
      end
   endfunction

endpackage

### rtl/b64_front.sv
module b64_front
   import b64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_message,
   input  logic        queue_full,
   output logic        queue_push,
   output group_type   queue_data
);

   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        accept;

   assign accept = req_push && !queue_full;

   always_comb begin
      held_bytes_in  = held_bytes_ff;
      held_count_in  = held_count_ff;
      queue_push     = 1'b0;
      queue_data     = '0;
      queue_data.eom = req_end_of_message;
      case (held_count_ff)
         HELD_TWO: begin
            queue_data.bits      = {held_bytes_ff, req_data_byte};
            queue_data.pad_count = 2'd0;
         end
         HELD_ONE: begin
            queue_data.bits      = {held_bytes_ff[15:8], req_data_byte, 8'h00};
            queue_data.pad_count = 2'd1;
         end
         default: begin
            queue_data.bits      = {req_data_byte, 16'h0000};
            queue_data.pad_count = 2'd2;
         end
      endcase
      if (accept) begin
         if (held_count_ff == HELD_TWO || req_end_of_message) begin
            queue_push    = 1'b1;
            held_bytes_in = '0;
            held_count_in = HELD_NONE;
         end else begin
            if (held_count_ff == HELD_NONE) begin
               held_bytes_in = {req_data_byte, 8'h00};
            end else begin
               held_bytes_in = {held_bytes_ff[15:8], req_data_byte};
            end
            held_count_in = held_count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= '0;
         held_count_ff <= HELD_NONE;
      end else begin
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
      end
   end

endmodule

### rtl/b64_queue.sv
module b64_queue
   import b64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  group_type  push_data,
   output logic       full,
   input  logic       pop,
   output group_type  pop_data,
   output logic       empty
);

   group_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_W-1:0] PTR_ONE  = QUEUE_PTR_W'(1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_ONE  = QUEUE_CNT_W'(1);

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/b64_back.sv
module b64_back
   import b64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  group_type  queue_data,
   input  logic       queue_empty,
   output logic       queue_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last
);

   group_type   group_ff, group_in;
   logic        busy_ff, busy_in;
   logic [1:0]  slot_ff, slot_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_char_ff, out_char_in;
   logic        out_last_ff, out_last_in;
   logic        advance, group_done;
   logic [5:0]  idx;
   logic        is_pad;

   // output register frees when empty or being taken this cycle
   assign advance    = busy_ff && (!out_valid_ff || rsp_pop);
   assign group_done = advance && (slot_ff == LAST_SLOT);
   assign queue_pop  = !queue_empty && (!busy_ff || group_done);

   always_comb begin
      case (slot_ff)
         2'd0:    idx = group_ff.bits[23:18];
         2'd1:    idx = group_ff.bits[17:12];
         2'd2:    idx = group_ff.bits[11:6];
         default: idx = group_ff.bits[5:0];
      endcase
   end

   assign is_pad = ({1'b0, slot_ff} + {1'b0, group_ff.pad_count}) > {1'b0, LAST_SLOT};

   always_comb begin
      group_in     = group_ff;
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_char_in  = is_pad ? PAD_CHAR : encode_char(idx);
         out_last_in  = (slot_ff == LAST_SLOT) && group_ff.eom;
         slot_in      = slot_ff + 2'd1;
         if (group_done) begin
            busy_in = 1'b0;
         end
      end
      if (queue_pop) begin
         group_in = queue_data;
         busy_in  = 1'b1;
         slot_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff    <= group_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_out_last = out_last_ff;

endmodule

### rtl/base64_stream_encoder.sv
// channel   | direction | handshake        | payload
// ----------+-----------+------------------+---------------------------------------
// request   | in        | req_push/req_full | req_data_byte, req_end_of_message
// response  | out       | rsp_pop/rsp_empty | rsp_out_char, rsp_out_last
//
// one request byte per cycle is taken while the group queue has room; the back end
// sends one character per cycle while rsp_pop takes them, four per group, all
// through the single character output register
// a group passes the queue and the group register before its first character shows
// reset is synchronous and active high; it empties the byte buffer, the queue
// and the output register, with no clearing pass
// req_full rises only while both queue slots hold groups; a stalled rsp_pop holds
// the current character and backs up through the queue to req_full
module base64_stream_encoder
   import b64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last
);

   // front to queue
   logic      front_push;
   group_type front_group;
   // queue to back
   logic      queue_full;
   logic      queue_empty;
   logic      back_pop;
   group_type back_group;

   // the front only ever waits on the queue
   assign req_full = queue_full;

   // byte buffer: groups bytes in threes, closes a short group on the end mark
   b64_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .queue_full         (queue_full),
      .queue_push         (front_push),
      .queue_data         (front_group)
   );

   // short group queue decouples byte intake from character output
   b64_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_group),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_data  (back_group),
      .empty     (queue_empty)
   );

   // character sequencer: four slots per group, alphabet lookup or padding,
   // next group loaded in the same cycle as the last slot so there is no gap
   b64_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_data   (back_group),
      .queue_empty  (queue_empty),
      .queue_pop    (back_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule

### rtl/b64_checker.sv
`include "assert_macros.svh"

module b64_checker
   import b64_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_char,
   input logic       rsp_out_last
);

   logic legal_char;
   logic pad_not_last_taken;
   logic char_waiting;

   assign legal_char =
      (rsp_out_char >= UPPER_BASE && rsp_out_char <= UPPER_LAST) ||
      (rsp_out_char >= LOWER_BASE && rsp_out_char <= LOWER_LAST) ||
      (rsp_out_char >= DIGIT_BASE && rsp_out_char <= DIGIT_LAST) ||
      rsp_out_char == PLUS_CHAR || rsp_out_char == SLASH_CHAR ||
      rsp_out_char == PAD_CHAR;

   assign pad_not_last_taken = rsp_pop && !rsp_empty && rsp_out_char == PAD_CHAR &&
                               !rsp_out_last;

   assign char_waiting = !rsp_empty && !rsp_pop;

   // nothing left to deliver after reset
   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> rsp_empty)

   // only alphabet or padding characters leave the block
   `ASSERT_CLK(a_legal_char, clock, reset, !rsp_empty |-> legal_char)

   // a first padding character is followed at once by the final one
   `ASSERT_CLK(a_pad_pair, clock, reset,
      pad_not_last_taken |=> (!rsp_empty && rsp_out_char == PAD_CHAR && rsp_out_last))

   // a character not taken stays put
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      char_waiting |=> (!rsp_empty && $stable(rsp_out_char) && $stable(rsp_out_last)))

endmodule

bind base64_stream_encoder b64_checker u_checker (.*);
